### src/bpa_pkg.sv
// Buddy page allocator: shared field widths, request codes and page record type.
// Depends on nothing; used by the channel interfaces and the allocator top level.
package bpa_pkg;

  localparam int MODE_W  = 2;
  localparam int ORDER_W = 4;
  localparam int PIDX_W  = 12;
  localparam int BLK_W   = 12;
  localparam int CNT_W   = 13;
  localparam int CFG_W   = 4;
  localparam int LVL_W   = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  localparam logic [LVL_W-1:0] NO_LEVEL  = 4'hF;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // Per-page record kept in the level memory
  typedef struct packed {
    logic             alloc;
    logic [LVL_W-1:0] level;
  } page_info_t;

endpackage

### src/bpa_if.sv
// Buddy page allocator channel interfaces: request, response and configuration write.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::MODE_W-1:0]  mode;
  logic [bpa_pkg::ORDER_W-1:0] order;
  logic [bpa_pkg::PIDX_W-1:0]  page_index;
  modport source (output valid, mode, order, page_index, input ready);
  modport sink   (input valid, mode, order, page_index, output ready);
endinterface

interface bpa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [bpa_pkg::BLK_W-1:0] block_index;
  logic [bpa_pkg::CNT_W-1:0] free_count;
  modport source (output valid, ok, block_index, free_count, input ready);
  modport sink   (input valid, ok, block_index, free_count, output ready);
endinterface

interface bpa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpa_pkg::CFG_W-1:0] region_top_blocks;
  modport source (output valid, region_top_blocks, input ready);
  modport sink   (input valid, region_top_blocks, output ready);
endinterface

### src/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/buddy_page_allocator_unit.sv
// Buddy page allocator top level: sequencer over page level, next and prev memories.
// Depends on bpa_pkg, bpa_if.sv interfaces and bpa_ram.
//
// Usage: requests arrive on req (mode, order, page_index); each request gives
// exactly one response on rsp (ok, block_index, free_count). cfg writes the
// region size in top-order blocks; write it only while the block is idle.
// A request is taken only while the sequencer is idle; the response sits in an
// output register, so a new request is taken while the previous response waits.
// Each request runs as a sequence of memory steps:
//   allocate: unlink the block, mark it, push the upper half of each split
//   free:     check each buddy, merge it while free, then push the block
//   init:     clear the level memory, then push each top block
//   a failed allocate or a rejected free goes straight to the response
// After reset the level memory is swept, one page a cycle; req.ready stays low
// during that sweep. If rsp stalls, the finished response holds and the sequencer
// waits before storing the next one.
// REGION_PAGES must be a power of two.
module buddy_page_allocator_unit #(
  parameter int MAX_ORDER    = 9,
  parameter int REGION_PAGES = 4096
) (
  input  logic   clk,
  input  logic   rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);

  localparam int PW   = $clog2(REGION_PAGES);
  localparam int LW   = PW + 1;
  localparam int NORD = MAX_ORDER + 1;
  localparam int OW   = (NORD > 1) ? $clog2(NORD) : 1;
  localparam int CAP  = REGION_PAGES >> MAX_ORDER;
  localparam int CW   = ((PW > bpa_pkg::PIDX_W) ? PW : bpa_pkg::PIDX_W) + 2;
  localparam logic [LW-1:0] NIL = LW'(REGION_PAGES);
  localparam logic [bpa_pkg::LVL_W-1:0] MAXO = bpa_pkg::LVL_W'(MAX_ORDER);

  typedef enum logic [13:0] {
    S_CLEAR      = 14'b00000000000001,
    S_IDLE       = 14'b00000000000010,
    S_UNLINK0    = 14'b00000000000100,
    S_UNLINK1    = 14'b00000000001000,
    S_UNLINK2    = 14'b00000000010000,
    S_PUSH0      = 14'b00000000100000,
    S_PUSH1      = 14'b00000001000000,
    S_ALLOC_MARK = 14'b00000010000000,
    S_SPLIT      = 14'b00000100000000,
    S_FREE_CHK   = 14'b00001000000000,
    S_FREE_EVAL  = 14'b00010000000000,
    S_FREE_DROP  = 14'b00100000000000,
    S_INIT_PUSH  = 14'b01000000000000,
    S_OUT        = 14'b10000000000000
  } state_t;

  state_t state;
  state_t ret;

  logic [LW-1:0]                  head [NORD];
  logic [bpa_pkg::CNT_W-1:0]      cnt  [NORD];
  logic [bpa_pkg::CFG_W-1:0]      rtb;
  logic [PW-1:0]                  clr_idx;
  logic                           init_run;
  logic [bpa_pkg::CFG_W-1:0]      ib;
  logic [PW-1:0]                  cur_p;
  logic [bpa_pkg::LVL_W-1:0]      cur_lvl;
  logic [PW-1:0]                  op_p;
  logic [bpa_pkg::LVL_W-1:0]      op_lvl;
  logic [LW-1:0]                  old_h;
  logic [bpa_pkg::ORDER_W-1:0]    ord_r;
  logic                           ok_r;
  logic [bpa_pkg::BLK_W-1:0]      blk_r;
  logic                           rsp_valid;
  logic                           rsp_ok;
  logic [bpa_pkg::BLK_W-1:0]      rsp_blk;
  logic [bpa_pkg::CNT_W-1:0]      rsp_cnt;

  // Memory ports
  logic                    lvl_we, lvl_re;
  logic [PW-1:0]           lvl_waddr, lvl_raddr;
  bpa_pkg::page_info_t     lvl_wdata, lvl_rdata;
  logic                    nx_we, pv_we, lk_re;
  logic [PW-1:0]           nx_waddr, pv_waddr, lk_raddr;
  logic [LW-1:0]           nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  // Request decode
  logic                    ord_ok, free_ok, found;
  logic [OW-1:0]           fidx;
  logic [CW-1:0]           pidx_ext, size, rp;
  logic [bpa_pkg::CFG_W-1:0] nblk;
  logic [PW-1:0]           pidx_p, buddy, half;
  logic [bpa_pkg::LVL_W-1:0] lvl_dn;
  logic [OW-1:0]           op_i;
  logic [bpa_pkg::CNT_W-1:0] cnt_sel;

  bpa_ram #(.WIDTH($bits(bpa_pkg::page_info_t)), .DEPTH(REGION_PAGES)) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .re(lvl_re), .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(REGION_PAGES)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(lk_re), .raddr(lk_raddr), .rdata(nx_rdata)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(REGION_PAGES)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(lk_re), .raddr(lk_raddr), .rdata(pv_rdata)
  );

  // Decode the incoming request and the region bounds
  always_comb begin
    ord_ok   = req.order <= bpa_pkg::ORDER_W'(MAX_ORDER);
    pidx_ext = CW'(req.page_index);
    size     = CW'(1) << req.order;
    nblk     = (int'(rtb) > CAP) ? bpa_pkg::CFG_W'(CAP) : rtb;
    rp       = CW'(nblk) << MAX_ORDER;
    free_ok  = ord_ok && ((pidx_ext & (size - CW'(1))) == '0) && (pidx_ext + size <= rp);
    pidx_p   = pidx_ext[PW-1:0];
    found    = 1'b0;
    fidx     = '0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (bpa_pkg::ORDER_W'(i) >= req.order && head[i] != NIL) begin
        found = 1'b1;
        fidx  = OW'(i);
      end
    end
    buddy   = cur_p ^ (PW'(1) << cur_lvl);
    lvl_dn  = cur_lvl - 1'b1;
    half    = cur_p + (PW'(1) << lvl_dn);
    op_i    = op_lvl[OW-1:0];
    cnt_sel = (ord_r <= bpa_pkg::ORDER_W'(MAX_ORDER)) ? cnt[ord_r[OW-1:0]] : '0;
  end

  // Drive memory accesses for the current step
  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = cur_p;
    lvl_wdata = '{alloc: 1'b0, level: bpa_pkg::NO_LEVEL};
    lvl_re    = 1'b0;
    lvl_raddr = buddy;
    nx_we     = 1'b0;
    nx_waddr  = op_p;
    nx_wdata  = NIL;
    pv_we     = 1'b0;
    pv_waddr  = op_p;
    pv_wdata  = NIL;
    lk_re     = 1'b0;
    lk_raddr  = op_p;
    unique case (state)
      S_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_waddr = clr_idx;
      end
      S_IDLE: begin
        if (req.valid && req.mode == bpa_pkg::MODE_FREE && free_ok) begin
          lvl_we    = 1'b1;
          lvl_waddr = pidx_p;
        end
      end
      S_UNLINK0: begin
        lk_re = 1'b1;
      end
      S_UNLINK1: begin
        if (pv_rdata < NIL) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[PW-1:0];
          nx_wdata = nx_rdata;
        end
        if (nx_rdata < NIL) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rdata[PW-1:0];
          pv_wdata = (pv_rdata < NIL) ? pv_rdata : NIL;
        end
      end
      S_UNLINK2: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      S_PUSH0: begin
        nx_we     = 1'b1;
        nx_wdata  = head[op_i];
        pv_we     = 1'b1;
        lvl_we    = 1'b1;
        lvl_waddr = op_p;
        lvl_wdata = '{alloc: 1'b0, level: op_lvl};
      end
      S_PUSH1: begin
        pv_we    = 1'b1;
        pv_waddr = old_h[PW-1:0];
        pv_wdata = LW'(op_p);
      end
      S_ALLOC_MARK: begin
        lvl_we    = 1'b1;
        lvl_wdata = '{alloc: 1'b1, level: bpa_pkg::LVL_W'(ord_r)};
      end
      S_FREE_CHK: begin
        lvl_re = cur_lvl < MAXO;
      end
      S_FREE_DROP: begin
        lvl_we    = 1'b1;
        lvl_waddr = buddy;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list heads and counts, response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= S_OUT;
      clr_idx   <= '0;
      init_run  <= 1'b0;
      rtb       <= bpa_pkg::CFG_RESET;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NORD; i++) begin
        head[i] <= NIL;
        cnt[i]  <= '0;
      end
    end else begin
      if (cfg.valid) begin
        rtb <= cfg.region_top_blocks;
      end
      // Drop the response once taken, unless a new one is stored this cycle
      if (rsp_valid && rsp.ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            ib    <= '0;
            state <= init_run ? S_INIT_PUSH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            ord_r <= req.order;
            ok_r  <= 1'b0;
            blk_r <= '0;
            unique case (req.mode)
              bpa_pkg::MODE_ALLOC: begin
                if (ord_ok && found) begin
                  cur_p   <= head[fidx][PW-1:0];
                  op_p    <= head[fidx][PW-1:0];
                  cur_lvl <= bpa_pkg::LVL_W'(fidx);
                  op_lvl  <= bpa_pkg::LVL_W'(fidx);
                  ret     <= S_ALLOC_MARK;
                  state   <= S_UNLINK0;
                end else begin
                  state <= S_OUT;
                end
              end
              bpa_pkg::MODE_FREE: begin
                if (free_ok) begin
                  cur_p   <= pidx_p;
                  cur_lvl <= req.order;
                  ok_r    <= 1'b1;
                  state   <= S_FREE_CHK;
                end else begin
                  state <= S_OUT;
                end
              end
              bpa_pkg::MODE_INIT: begin
                init_run <= 1'b1;
                clr_idx  <= '0;
                ok_r     <= 1'b1;
                for (int i = 0; i < NORD; i++) begin
                  head[i] <= NIL;
                  cnt[i]  <= '0;
                end
                state <= S_CLEAR;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_UNLINK0: begin
          state <= S_UNLINK1;
        end
        S_UNLINK1: begin
          if (!(pv_rdata < NIL) && head[op_i] == LW'(op_p)) begin
            head[op_i] <= (nx_rdata < NIL) ? nx_rdata : NIL;
          end
          cnt[op_i] <= cnt[op_i] - 1'b1;
          state     <= S_UNLINK2;
        end
        S_UNLINK2: begin
          state <= ret;
        end
        S_PUSH0: begin
          old_h      <= head[op_i];
          head[op_i] <= LW'(op_p);
          cnt[op_i]  <= cnt[op_i] + 1'b1;
          state      <= (head[op_i] < NIL) ? S_PUSH1 : ret;
        end
        S_PUSH1: begin
          state <= ret;
        end
        S_ALLOC_MARK: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          // Push the upper half of each split onto the next lower list
          if (cur_lvl > bpa_pkg::LVL_W'(ord_r)) begin
            cur_lvl <= lvl_dn;
            op_p    <= half;
            op_lvl  <= lvl_dn;
            ret     <= S_SPLIT;
            state   <= S_PUSH0;
          end else begin
            ok_r  <= 1'b1;
            blk_r <= bpa_pkg::BLK_W'(cur_p);
            state <= S_OUT;
          end
        end
        S_FREE_CHK: begin
          if (cur_lvl < MAXO) begin
            state <= S_FREE_EVAL;
          end else begin
            op_p   <= cur_p;
            op_lvl <= cur_lvl;
            ret    <= S_OUT;
            state  <= S_PUSH0;
          end
        end
        S_FREE_EVAL: begin
          // Merge with a free buddy of equal level, else push the block
          if (lvl_rdata.level == cur_lvl && !lvl_rdata.alloc) begin
            op_p   <= buddy;
            op_lvl <= cur_lvl;
            ret    <= S_FREE_DROP;
            state  <= S_UNLINK0;
          end else begin
            op_p   <= cur_p;
            op_lvl <= cur_lvl;
            ret    <= S_OUT;
            state  <= S_PUSH0;
          end
        end
        S_FREE_DROP: begin
          cur_p   <= cur_p & buddy;
          cur_lvl <= cur_lvl + 1'b1;
          state   <= S_FREE_CHK;
        end
        S_INIT_PUSH: begin
          if (ib < nblk) begin
            op_p   <= PW'(ib) << MAX_ORDER;
            op_lvl <= MAXO;
            ib     <= ib + 1'b1;
            ret    <= S_INIT_PUSH;
            state  <= S_PUSH0;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the response register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_ok    <= ok_r;
            rsp_blk   <= blk_r;
            rsp_cnt   <= cnt_sel;
            init_run  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.block_index = rsp_blk;
  assign rsp.free_count  = rsp_cnt;

  // A block being split stays aligned to its size
  a_split_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> (cur_p & ((PW'(1) << cur_lvl) - 1'b1)) == '0)
    else $error("split block misaligned");

  // Level data is only evaluated the cycle after its read was issued
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_FREE_EVAL |-> $past(state) == S_FREE_CHK && $past(lvl_re))
    else $error("buddy level evaluated without a read");

  // A stalled response is never overwritten
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && rsp_valid && !rsp.ready |=> state == S_OUT)
    else $error("response overwritten while stalled");

  // One request at a time: no request taken right after another
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

endmodule
